FILE: sv/obstacle_avoid_mode_controller_assert.svh
// ----------------------------------------------------------------------------
// obstacle_avoid_mode_controller assertion macros
// Shorthand for the concurrent checks on the drive mode controller ports.
// ----------------------------------------------------------------------------
`ifndef OBSTACLE_AVOID_MODE_CONTROLLER_ASSERT_SVH
`define OBSTACLE_AVOID_MODE_CONTROLLER_ASSERT_SVH

// check that is held off while reset is high
`define OAMC_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("oamc assertion failed");

// check that also runs through reset
`define OAMC_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("oamc assertion failed");

`endif

FILE: sv/oamc_pkg.sv
// ----------------------------------------------------------------------------
// oamc_pkg
// Shared codes, constants and types of the obstacle avoid mode controller.
// ----------------------------------------------------------------------------
`default_nettype none

package oamc_pkg;

   // drive mode codes
   localparam int MODE_W = 3;
   localparam logic [MODE_W-1:0] MODE_IDLE = 3'd0;
   localparam logic [MODE_W-1:0] MODE_FWD  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_TL   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_TR   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_AVL  = 3'd4;
   localparam logic [MODE_W-1:0] MODE_AVR  = 3'd5;
   localparam logic [MODE_W-1:0] MODE_REV  = 3'd6;
   localparam logic [MODE_W-1:0] MODE_STOP = 3'd7;

   // control register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_SAFE_DISTANCE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CRITICAL_DISTANCE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CRUISE_SPEED      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TURN_SPEED        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_REVERSE_SPEED     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SLEW_STEP         = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_BATTERY_MIN_MV    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_IR_THRESHOLD      = 3'd7;
   localparam int CSR_DATA_W = 13;

   // field widths
   localparam int TIME_W  = 32;
   localparam int DIST_W  = 9;
   localparam int ADC_W   = 12;
   localparam int SPEED_W = 10;
   localparam int MV_W    = 13;
   localparam int WHEEL_W = 11;
   localparam int TGT_W   = 12;
   localparam int DUTY_W  = 10;

   // speed and duty scaling
   localparam int SPEED_LIMIT     = 800;
   localparam int DUTY_FULL_SCALE = 1000;
   // full scale over speed limit reduces to a power-of-two denominator
   localparam int DUTY_DEN_SHIFT  = 2;
   localparam int DUTY_NUM        = (DUTY_FULL_SCALE << DUTY_DEN_SHIFT) / SPEED_LIMIT;

   // time in mode limits, ms
   localparam int TURN_TIME_MS    = 500;
   localparam int AVOID_TIME_MS   = 800;
   localparam int REVERSE_TIME_MS = 300;
   localparam int STOP_TIME_MS    = 1000;
   localparam int STOP_CLEAR_CM   = 5;

   // battery code to millivolt scale
   localparam int BAT_FULL_MV = 6600;
   localparam int ADC_FULL    = 4095;
   localparam int BAT_CMP_W   = 26;

   // reset values of the control registers
   localparam logic [DIST_W-1:0]  RST_SAFE_DISTANCE     = 9'd20;
   localparam logic [DIST_W-1:0]  RST_CRITICAL_DISTANCE = 9'd10;
   localparam logic [SPEED_W-1:0] RST_CRUISE_SPEED      = 10'd800;
   localparam logic [SPEED_W-1:0] RST_TURN_SPEED        = 10'd600;
   localparam logic [SPEED_W-1:0] RST_REVERSE_SPEED     = 10'd200;
   localparam logic [SPEED_W-1:0] RST_SLEW_STEP         = 10'd50;
   localparam logic [MV_W-1:0]    RST_BATTERY_MIN_MV    = 13'd3300;
   localparam logic [ADC_W-1:0]   RST_IR_THRESHOLD      = 12'd2000;

   // per wheel command from the mode logic
   typedef struct packed {
      logic signed [TGT_W-1:0] target;
      logic                    hold;
   } wheel_cmd_type;

   // forward and reverse pwm duty of one wheel
   typedef struct packed {
      logic [DUTY_W-1:0] fwd;
      logic [DUTY_W-1:0] rev;
   } duty_type;

endpackage

`default_nettype wire

FILE: sv/oamc_wheel.sv
// ----------------------------------------------------------------------------
// oamc_wheel
// Clamps one wheel target, slews the applied speed toward it unless told to
// hold, and derives the forward and reverse pwm duties from the new speed.
// ----------------------------------------------------------------------------
`default_nettype none

module oamc_wheel (
   input  logic signed [oamc_pkg::WHEEL_W-1:0] cur_speed,
   input  oamc_pkg::wheel_cmd_type              cmd,
   input  logic [oamc_pkg::SPEED_W-1:0]         slew_step,
   output logic signed [oamc_pkg::WHEEL_W-1:0] next_speed,
   output oamc_pkg::duty_type                   duty
);

   localparam int TGT_W   = oamc_pkg::TGT_W;
   localparam int WHEEL_W = oamc_pkg::WHEEL_W;
   localparam int DUTY_W  = oamc_pkg::DUTY_W;
   localparam int SHIFT   = oamc_pkg::DUTY_DEN_SHIFT;
   localparam int PROD_W  = WHEEL_W + $clog2(oamc_pkg::DUTY_NUM + 1);

   localparam logic signed [TGT_W-1:0] LIM_POS = TGT_W'(oamc_pkg::SPEED_LIMIT);
   localparam logic signed [TGT_W-1:0] LIM_NEG = -LIM_POS;

   logic signed [TGT_W-1:0] clamped;
   logic signed [TGT_W-1:0] cur_ext;
   logic signed [TGT_W-1:0] diff;
   logic signed [TGT_W-1:0] step_pos;
   logic signed [TGT_W-1:0] step_neg;
   logic signed [TGT_W-1:0] slewed;
   logic [WHEEL_W-1:0]      mag;
   logic [PROD_W-1:0]       scaled;
   logic [DUTY_W-1:0]       duty_val;
   logic                    is_neg;
   logic                    is_pos;

   // clamp target to the speed limit
   always_comb begin
      if (cmd.target > LIM_POS) begin
         clamped = LIM_POS;
      end else if (cmd.target < LIM_NEG) begin
         clamped = LIM_NEG;
      end else begin
         clamped = cmd.target;
      end
   end

   // slew toward the clamped target by at most one step
   assign cur_ext  = {cur_speed[WHEEL_W-1], cur_speed};
   assign diff     = clamped - cur_ext;
   assign step_pos = signed'({{(TGT_W-oamc_pkg::SPEED_W){1'b0}}, slew_step});
   assign step_neg = -step_pos;

   always_comb begin
      if (diff > step_pos) begin
         slewed = cur_ext + step_pos;
      end else if (diff < step_neg) begin
         slewed = cur_ext - step_pos;
      end else begin
         slewed = clamped;
      end
   end

   assign next_speed = cmd.hold ? cur_speed : slewed[WHEEL_W-1:0];

   // duty from the magnitude of the new speed
   assign is_neg   = next_speed[WHEEL_W-1];
   assign is_pos   = !is_neg && (next_speed != '0);
   assign mag      = is_neg ? WHEEL_W'(-next_speed) : WHEEL_W'(next_speed);
   assign scaled   = PROD_W'(mag) * PROD_W'(oamc_pkg::DUTY_NUM);
   assign duty_val = scaled[DUTY_W+SHIFT-1:SHIFT];

   assign duty.fwd = is_pos ? duty_val : '0;
   assign duty.rev = is_neg ? duty_val : '0;

endmodule

`default_nettype wire

FILE: sv/obstacle_avoid_mode_controller.sv
// ----------------------------------------------------------------------------
// obstacle_avoid_mode_controller
// Drive mode state machine with wheel slew limiting and pwm duty output.
// ----------------------------------------------------------------------------
// One sensor tick is taken per clock cycle while rsp_ready does not stall
// the output. A tick lands in an input register, the mode rules, wheel
// slew and duty math run combinationally behind it, and the result sits in
// an output register. The mode, entry time and wheel speeds update
// with the output register as a tick moves on, which is what lets the
// next tick follow right behind. The input stage stalls while a result
// waits on rsp_ready and moves again once the output register drains.
// Control registers are written through csr_write_en, csr_index and
// csr_wdata and should only change while no tick is in flight.
`default_nettype none

module obstacle_avoid_mode_controller (
   input  logic                                 clock,
   input  logic                                 reset,
   // sensor tick
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [oamc_pkg::TIME_W-1:0]          req_now_ms,
   input  logic [oamc_pkg::DIST_W-1:0]          req_front_cm,
   input  logic [oamc_pkg::DIST_W-1:0]          req_left_cm,
   input  logic [oamc_pkg::DIST_W-1:0]          req_right_cm,
   input  logic [oamc_pkg::ADC_W-1:0]           req_center_ir_adc,
   input  logic [oamc_pkg::ADC_W-1:0]           req_battery_adc,
   // drive result
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [oamc_pkg::DUTY_W-1:0]          rsp_left_fwd_duty,
   output logic [oamc_pkg::DUTY_W-1:0]          rsp_left_rev_duty,
   output logic [oamc_pkg::DUTY_W-1:0]          rsp_right_fwd_duty,
   output logic [oamc_pkg::DUTY_W-1:0]          rsp_right_rev_duty,
   output logic signed [oamc_pkg::WHEEL_W-1:0]  rsp_left_speed,
   output logic signed [oamc_pkg::WHEEL_W-1:0]  rsp_right_speed,
   output logic [oamc_pkg::MODE_W-1:0]          rsp_drive_mode,
   output logic                                 rsp_emergency_stop,
   // control registers
   input  logic                                 csr_write_en,
   input  logic [oamc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [oamc_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int TIME_W    = oamc_pkg::TIME_W;
   localparam int DIST_W    = oamc_pkg::DIST_W;
   localparam int ADC_W     = oamc_pkg::ADC_W;
   localparam int SPEED_W   = oamc_pkg::SPEED_W;
   localparam int MV_W      = oamc_pkg::MV_W;
   localparam int WHEEL_W   = oamc_pkg::WHEEL_W;
   localparam int TGT_W     = oamc_pkg::TGT_W;
   localparam int DUTY_W    = oamc_pkg::DUTY_W;
   localparam int MODE_W    = oamc_pkg::MODE_W;
   localparam int BAT_CMP_W = oamc_pkg::BAT_CMP_W;

   // control registers
   logic [DIST_W-1:0]  safe_distance_ff;
   logic [DIST_W-1:0]  critical_distance_ff;
   logic [SPEED_W-1:0] cruise_speed_ff;
   logic [SPEED_W-1:0] turn_speed_ff;
   logic [SPEED_W-1:0] reverse_speed_ff;
   logic [SPEED_W-1:0] slew_step_ff;
   logic [MV_W-1:0]    battery_min_mv_ff;
   logic [ADC_W-1:0]   ir_threshold_ff;

   // input stage
   logic               in_valid_ff;
   logic               in_valid_in;
   logic [TIME_W-1:0]  in_now_ff;
   logic [DIST_W-1:0]  in_front_ff;
   logic [DIST_W-1:0]  in_left_ff;
   logic [DIST_W-1:0]  in_right_ff;
   logic [ADC_W-1:0]   in_ir_ff;
   logic [ADC_W-1:0]   in_bat_ff;

   // controller state
   logic [MODE_W-1:0]         mode_ff;
   logic [MODE_W-1:0]         mode_in;
   logic [MODE_W-1:0]         prev_mode_ff;
   logic [TIME_W-1:0]         entry_time_ff;
   logic [TIME_W-1:0]         entry_time_in;
   logic signed [WHEEL_W-1:0] left_wheel_ff;
   logic signed [WHEEL_W-1:0] left_wheel_in;
   logic signed [WHEEL_W-1:0] right_wheel_ff;
   logic signed [WHEEL_W-1:0] right_wheel_in;

   // output stage
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   oamc_pkg::duty_type        left_duty_ff;
   oamc_pkg::duty_type        right_duty_ff;
   logic signed [WHEEL_W-1:0] left_speed_ff;
   logic signed [WHEEL_W-1:0] right_speed_ff;
   logic [MODE_W-1:0]         drive_mode_ff;
   logic                      estop_ff;
   logic                      estop_in;

   // datapath
   logic                    advance;
   logic                    obstacle;
   logic [TIME_W-1:0]       dt;
   logic [BAT_CMP_W-1:0]    bat_scaled;
   logic [BAT_CMP_W-1:0]    bat_limit;
   logic                    bat_low;
   logic [DIST_W:0]         stop_clear_cm;
   logic signed [TGT_W-1:0] cruise_tgt;
   logic signed [TGT_W-1:0] turn_tgt;
   logic signed [TGT_W-1:0] rev_tgt;
   oamc_pkg::wheel_cmd_type left_cmd;
   oamc_pkg::wheel_cmd_type right_cmd;
   oamc_pkg::duty_type      left_duty;
   oamc_pkg::duty_type      right_duty;

   // control register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         safe_distance_ff     <= oamc_pkg::RST_SAFE_DISTANCE;
         critical_distance_ff <= oamc_pkg::RST_CRITICAL_DISTANCE;
         cruise_speed_ff      <= oamc_pkg::RST_CRUISE_SPEED;
         turn_speed_ff        <= oamc_pkg::RST_TURN_SPEED;
         reverse_speed_ff     <= oamc_pkg::RST_REVERSE_SPEED;
         slew_step_ff         <= oamc_pkg::RST_SLEW_STEP;
         battery_min_mv_ff    <= oamc_pkg::RST_BATTERY_MIN_MV;
         ir_threshold_ff      <= oamc_pkg::RST_IR_THRESHOLD;
      end else if (csr_write_en) begin
         case (csr_index)
            oamc_pkg::CSR_SAFE_DISTANCE:     safe_distance_ff     <= csr_wdata[DIST_W-1:0];
            oamc_pkg::CSR_CRITICAL_DISTANCE: critical_distance_ff <= csr_wdata[DIST_W-1:0];
            oamc_pkg::CSR_CRUISE_SPEED:      cruise_speed_ff      <= csr_wdata[SPEED_W-1:0];
            oamc_pkg::CSR_TURN_SPEED:        turn_speed_ff        <= csr_wdata[SPEED_W-1:0];
            oamc_pkg::CSR_REVERSE_SPEED:     reverse_speed_ff     <= csr_wdata[SPEED_W-1:0];
            oamc_pkg::CSR_SLEW_STEP:         slew_step_ff         <= csr_wdata[SPEED_W-1:0];
            oamc_pkg::CSR_BATTERY_MIN_MV:    battery_min_mv_ff    <= csr_wdata[MV_W-1:0];
            oamc_pkg::CSR_IR_THRESHOLD:      ir_threshold_ff      <= csr_wdata[ADC_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // handshake: the tick moves on when the output register is free or drains
   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready    = !in_valid_ff || advance;
   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   // input beat capture
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_now_ff   <= req_now_ms;
         in_front_ff <= req_front_cm;
         in_left_ff  <= req_left_cm;
         in_right_ff <= req_right_cm;
         in_ir_ff    <= req_center_ir_adc;
         in_bat_ff   <= req_battery_adc;
      end
   end

   // entry time follows a mode change seen at the start of the tick
   assign entry_time_in = (mode_ff != prev_mode_ff) ? in_now_ff : entry_time_ff;
   assign dt            = in_now_ff - entry_time_in;

   // battery low when code*6600/4095 < min, compared without a divide
   assign bat_scaled = BAT_CMP_W'(in_bat_ff) * BAT_CMP_W'(oamc_pkg::BAT_FULL_MV);
   assign bat_limit  = BAT_CMP_W'(battery_min_mv_ff) * BAT_CMP_W'(oamc_pkg::ADC_FULL);
   assign bat_low    = bat_scaled < bat_limit;

   assign obstacle      = in_ir_ff > ir_threshold_ff;
   assign stop_clear_cm = (DIST_W+1)'(critical_distance_ff)
                        + (DIST_W+1)'(oamc_pkg::STOP_CLEAR_CM);

   assign cruise_tgt = signed'(TGT_W'(cruise_speed_ff));
   assign turn_tgt   = signed'(TGT_W'(turn_speed_ff));
   assign rev_tgt    = signed'(TGT_W'(reverse_speed_ff));

   // mode rules and wheel targets
   always_comb begin
      mode_in          = mode_ff;
      estop_in         = 1'b0;
      left_cmd.target  = '0;
      left_cmd.hold    = 1'b0;
      right_cmd.target = '0;
      right_cmd.hold   = 1'b0;
      if (bat_low) begin
         estop_in = 1'b1;
         mode_in  = oamc_pkg::MODE_STOP;
      end else begin
         case (mode_ff)
            oamc_pkg::MODE_IDLE: begin
            end
            oamc_pkg::MODE_FWD: begin
               if (in_front_ff > safe_distance_ff && !obstacle) begin
                  left_cmd.target  = cruise_tgt;
                  right_cmd.target = cruise_tgt;
               end else if (in_front_ff < critical_distance_ff || obstacle) begin
                  estop_in = 1'b1;
                  mode_in  = oamc_pkg::MODE_REV;
               end else begin
                  left_cmd.hold  = 1'b1;
                  right_cmd.hold = 1'b1;
                  if (in_front_ff < safe_distance_ff) begin
                     mode_in = (in_left_ff > in_right_ff) ? oamc_pkg::MODE_AVL
                                                          : oamc_pkg::MODE_AVR;
                  end
               end
            end
            oamc_pkg::MODE_TL, oamc_pkg::MODE_AVL: begin
               left_cmd.target  = -turn_tgt;
               right_cmd.target = turn_tgt;
               if (mode_ff == oamc_pkg::MODE_TL) begin
                  if (dt > TIME_W'(oamc_pkg::TURN_TIME_MS)) begin
                     mode_in = oamc_pkg::MODE_FWD;
                  end
               end else if (dt > TIME_W'(oamc_pkg::AVOID_TIME_MS)
                            && in_front_ff > safe_distance_ff) begin
                  mode_in = oamc_pkg::MODE_FWD;
               end
            end
            oamc_pkg::MODE_TR, oamc_pkg::MODE_AVR: begin
               left_cmd.target  = turn_tgt;
               right_cmd.target = -turn_tgt;
               if (mode_ff == oamc_pkg::MODE_TR) begin
                  if (dt > TIME_W'(oamc_pkg::TURN_TIME_MS)) begin
                     mode_in = oamc_pkg::MODE_FWD;
                  end
               end else if (dt > TIME_W'(oamc_pkg::AVOID_TIME_MS)
                            && in_front_ff > safe_distance_ff) begin
                  mode_in = oamc_pkg::MODE_FWD;
               end
            end
            oamc_pkg::MODE_REV: begin
               left_cmd.target  = -rev_tgt;
               right_cmd.target = -rev_tgt;
               if (dt > TIME_W'(oamc_pkg::REVERSE_TIME_MS)) begin
                  mode_in = (in_left_ff > in_right_ff) ? oamc_pkg::MODE_TL
                                                       : oamc_pkg::MODE_TR;
               end
            end
            default: begin
               // stop: wait, then back off once the front clears
               if (dt > TIME_W'(oamc_pkg::STOP_TIME_MS)
                   && {1'b0, in_front_ff} > stop_clear_cm) begin
                  mode_in = oamc_pkg::MODE_REV;
               end
            end
         endcase
      end
   end

   // wheel slew and duty
   oamc_wheel u_left_wheel (
      .cur_speed  (left_wheel_ff),
      .cmd        (left_cmd),
      .slew_step  (slew_step_ff),
      .next_speed (left_wheel_in),
      .duty       (left_duty)
   );

   oamc_wheel u_right_wheel (
      .cur_speed  (right_wheel_ff),
      .cmd        (right_cmd),
      .slew_step  (slew_step_ff),
      .next_speed (right_wheel_in),
      .duty       (right_duty)
   );

   // controller state update
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= oamc_pkg::MODE_FWD;
         prev_mode_ff   <= oamc_pkg::MODE_IDLE;
         entry_time_ff  <= '0;
         left_wheel_ff  <= '0;
         right_wheel_ff <= '0;
      end else if (advance) begin
         mode_ff        <= mode_in;
         prev_mode_ff   <= mode_ff;
         entry_time_ff  <= entry_time_in;
         left_wheel_ff  <= left_wheel_in;
         right_wheel_ff <= right_wheel_in;
      end
   end

   // output beat
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         left_duty_ff   <= left_duty;
         right_duty_ff  <= right_duty;
         left_speed_ff  <= left_wheel_in;
         right_speed_ff <= right_wheel_in;
         drive_mode_ff  <= mode_in;
         estop_ff       <= estop_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_left_fwd_duty  = left_duty_ff.fwd;
   assign rsp_left_rev_duty  = left_duty_ff.rev;
   assign rsp_right_fwd_duty = right_duty_ff.fwd;
   assign rsp_right_rev_duty = right_duty_ff.rev;
   assign rsp_left_speed     = left_speed_ff;
   assign rsp_right_speed    = right_speed_ff;
   assign rsp_drive_mode     = drive_mode_ff;
   assign rsp_emergency_stop = estop_ff;

endmodule

`default_nettype wire

FILE: sv/oamc_checker.sv
// ----------------------------------------------------------------------------
// oamc_checker
// Port level checks of the obstacle avoid mode controller, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "obstacle_avoid_mode_controller_assert.svh"

module oamc_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic [oamc_pkg::TIME_W-1:0]          req_now_ms,
   input logic [oamc_pkg::DIST_W-1:0]          req_front_cm,
   input logic [oamc_pkg::DIST_W-1:0]          req_left_cm,
   input logic [oamc_pkg::DIST_W-1:0]          req_right_cm,
   input logic [oamc_pkg::ADC_W-1:0]           req_center_ir_adc,
   input logic [oamc_pkg::ADC_W-1:0]           req_battery_adc,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic [oamc_pkg::DUTY_W-1:0]          rsp_left_fwd_duty,
   input logic [oamc_pkg::DUTY_W-1:0]          rsp_left_rev_duty,
   input logic [oamc_pkg::DUTY_W-1:0]          rsp_right_fwd_duty,
   input logic [oamc_pkg::DUTY_W-1:0]          rsp_right_rev_duty,
   input logic signed [oamc_pkg::WHEEL_W-1:0]  rsp_left_speed,
   input logic signed [oamc_pkg::WHEEL_W-1:0]  rsp_right_speed,
   input logic [oamc_pkg::MODE_W-1:0]          rsp_drive_mode,
   input logic                                 rsp_emergency_stop,
   input logic                                 csr_write_en,
   input logic [oamc_pkg::CSR_IDX_W-1:0]       csr_index,
   input logic [oamc_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int WHEEL_W = oamc_pkg::WHEEL_W;
   localparam logic signed [WHEEL_W-1:0] LIM_POS = WHEEL_W'(oamc_pkg::SPEED_LIMIT);
   localparam logic signed [WHEEL_W-1:0] LIM_NEG = -LIM_POS;

   // a stalled result beat holds its payload
   `OAMC_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_left_speed) && $stable(rsp_right_speed) && $stable(rsp_drive_mode) && $stable(rsp_emergency_stop))

   // no result beat right after reset
   `OAMC_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid)

   // the left speed stays inside the limit, and the left forward and right reverse duties follow their wheel's sign
   `OAMC_ASSERT(a_speed_duty, rsp_valid |-> rsp_left_speed <= LIM_POS && rsp_left_speed >= LIM_NEG && ((rsp_left_fwd_duty != '0) == (rsp_left_speed > 0)) && ((rsp_right_rev_duty != '0) == (rsp_right_speed < 0)))

   // an emergency stop leaves the block stopped or reversing
   `OAMC_ASSERT(a_estop_mode, rsp_valid && rsp_emergency_stop |-> rsp_drive_mode == oamc_pkg::MODE_STOP || rsp_drive_mode == oamc_pkg::MODE_REV)

endmodule

bind obstacle_avoid_mode_controller oamc_checker u_oamc_checker (.*);

`default_nettype wire
